### rtl/nbdf_pkg.sv
// ----------------------------------------------------------------------------
// nbdf_pkg
// Types and constants shared by the nine-bit datagram filter.
// ----------------------------------------------------------------------------
package nbdf_pkg;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_ATTR = 2'd1,
        PH_DATA = 2'd2
    } phase_t;

    localparam logic [1:0] ST_STORED   = 2'd0;
    localparam logic [1:0] ST_DONE     = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_ID_A    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ID_B    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ID_C    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ID_D    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_LEN = 3'd4;

    localparam logic [7:0] RST_ID_A    = 8'h00;
    localparam logic [7:0] RST_ID_B    = 8'h10;
    localparam logic [7:0] RST_ID_C    = 8'h11;
    localparam logic [7:0] RST_ID_D    = 8'h20;
    localparam logic [3:0] RST_MIN_LEN = 4'd3;

    // common width for position / length compares
    localparam int CMP_W = 6;

    typedef struct packed {
        logic [7:0] id_a;
        logic [7:0] id_b;
        logic [7:0] id_c;
        logic [7:0] id_d;
        logic [3:0] min_length;
    } cfg_t;

    typedef struct packed {
        logic [7:0] byte_value;
        logic [4:0] byte_index;
        logic       last;
        logic [1:0] status;
    } result_t;

endpackage

### rtl/nbdf_if.sv
// ----------------------------------------------------------------------------
// nbdf_serial_if / nbdf_result_if
// Valid/ready channels for incoming serial words and outgoing results.
// ----------------------------------------------------------------------------
interface nbdf_serial_if;
    logic       valid;
    logic       ready;
    logic       command_flag;
    logic [7:0] word_byte;

    modport source (output valid, output command_flag, output word_byte, input ready);
    modport sink   (input valid, input command_flag, input word_byte, output ready);
endinterface

interface nbdf_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic [4:0] byte_index;
    logic       last;
    logic [1:0] status;

    modport source (output valid, output byte_value, output byte_index, output last,
                    output status, input ready);
    modport sink   (input valid, input byte_value, input byte_index, input last,
                    input status, output ready);
endinterface

### rtl/nbdf_cfg.sv
// ----------------------------------------------------------------------------
// nbdf_cfg
// Configuration register file: accepted identifiers and minimum length.
// ----------------------------------------------------------------------------
module nbdf_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [nbdf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [nbdf_pkg::CFG_DATA_W-1:0] cfg_data,
    output nbdf_pkg::cfg_t                 cfg
);
    import nbdf_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_ID_A:    cfg_next.id_a       = cfg_data;
                REG_ID_B:    cfg_next.id_b       = cfg_data;
                REG_ID_C:    cfg_next.id_c       = cfg_data;
                REG_ID_D:    cfg_next.id_d       = cfg_data;
                REG_MIN_LEN: cfg_next.min_length = cfg_data[3:0];
                default:     cfg_next            = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.id_a       <= RST_ID_A;
            cfg_reg.id_b       <= RST_ID_B;
            cfg_reg.id_c       <= RST_ID_C;
            cfg_reg.id_d       <= RST_ID_D;
            cfg_reg.min_length <= RST_MIN_LEN;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/nbdf_core.sv
// ----------------------------------------------------------------------------
// nbdf_core
// Datagram framing state machine; forms at most one result per word.
// ----------------------------------------------------------------------------
module nbdf_core #(
    parameter int BUFFER_CAPACITY = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic              command_flag,
    input  logic [7:0]        word_byte,
    input  nbdf_pkg::cfg_t    cfg,
    output logic              has_result,
    output nbdf_pkg::result_t result
);
    import nbdf_pkg::*;

    localparam int POS_W = $clog2(BUFFER_CAPACITY + 1);

    phase_t           phase_reg, phase_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [4:0]       tlen_reg, tlen_next;

    logic [POS_W-1:0] pos_inc;
    logic             id_hit;
    logic             room;
    logic             ends;

    assign pos_inc = pos_reg + POS_W'(1);
    assign id_hit  = command_flag &&
                     (word_byte == cfg.id_a || word_byte == cfg.id_b ||
                      word_byte == cfg.id_c || word_byte == cfg.id_d);
    assign room    = pos_reg < POS_W'(BUFFER_CAPACITY);
    assign ends    = CMP_W'(pos_inc) >= CMP_W'(tlen_reg);

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        tlen_next  = tlen_reg;
        if (accept)
        begin
            case (phase_reg)
                PH_ATTR:
                begin
                    tlen_next  = 5'({1'b0, word_byte[3:0]}) + 5'({1'b0, cfg.min_length});
                    pos_next   = pos_inc;
                    phase_next = PH_DATA;
                end
                PH_DATA:
                begin
                    if (room)
                    begin
                        pos_next = pos_inc;
                        if (ends)
                        begin
                            phase_next = PH_HUNT;
                        end
                    end
                    else
                    begin
                        phase_next = PH_HUNT;
                    end
                end
                default:
                begin
                    phase_next = PH_HUNT;
                    if (id_hit)
                    begin
                        pos_next   = POS_W'(1);
                        phase_next = PH_ATTR;
                    end
                end
            endcase
        end
    end

    // outputs
    always_comb
    begin
        has_result        = 1'b0;
        result.byte_value = word_byte;
        result.byte_index = 5'(CMP_W'(pos_reg));
        result.last       = 1'b0;
        result.status     = ST_STORED;
        case (phase_reg)
            PH_ATTR:
            begin
                has_result        = accept;
                result.byte_value = {4'd0, word_byte[3:0]};
            end
            PH_DATA:
            begin
                has_result = accept;
                if (!room)
                begin
                    result.byte_value = 8'd0;
                    result.byte_index = 5'd0;
                    result.last       = 1'b1;
                    result.status     = ST_OVERFLOW;
                end
                else if (ends)
                begin
                    result.last   = 1'b1;
                    result.status = ST_DONE;
                end
            end
            default:
            begin
                has_result        = accept && id_hit;
                result.byte_index = 5'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            pos_reg   <= '0;
            tlen_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            tlen_reg  <= tlen_next;
        end
    end

endmodule

### rtl/nbdf_out_buf.sv
// ----------------------------------------------------------------------------
// nbdf_out_buf
// Result register with a skid word; input stalls only when both words are full.
// ----------------------------------------------------------------------------
module nbdf_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  nbdf_pkg::result_t push_word,
    output logic              can_take,
    output logic              out_valid,
    input  logic              out_ready,
    output nbdf_pkg::result_t out_word
);
    import nbdf_pkg::*;

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_word_reg, out_word_next;
    result_t skid_word_reg, skid_word_next;
    logic    pop;

    assign pop      = out_valid_reg && out_ready;
    assign can_take = !skid_valid_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_word_next   = out_word_reg;
        skid_word_next  = skid_word_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                out_word_next   = skid_word_reg;
                skid_valid_next = 1'b0;
            end
            else if (push)
            begin
                out_word_next = push_word;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg)
            begin
                out_word_next  = push_word;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_word_next  = push_word;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg  <= out_word_next;
        skid_word_reg <= skid_word_next;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

### rtl/nine_bit_datagram_filter.sv
// Each result is registered into the output stage when the word that causes it is accepted.
// Throughput: one word per cycle while the output stage is not full.
// A two-word output stage holds results while the sink stalls; input stalls only
// when both output words are full.
// Reset (rst_n low, asynchronous): hunting, no results pending, registers at defaults.
// ----------------------------------------------------------------------------
// nine_bit_datagram_filter
// Frames datagrams with accepted identifiers out of a nine-bit word stream.
// ----------------------------------------------------------------------------
module nine_bit_datagram_filter #(
    parameter int BUFFER_CAPACITY = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    nbdf_serial_if.sink                     serial,
    nbdf_result_if.source                   datagram,
    input  logic                            cfg_we,
    input  logic [nbdf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [nbdf_pkg::CFG_DATA_W-1:0] cfg_data
);
    import nbdf_pkg::*;

    cfg_t    cfg;
    logic    accept;
    logic    can_take;
    logic    has_result;
    result_t result;
    result_t out_word;

    assign serial.ready = can_take;
    assign accept       = serial.valid && can_take;

    nbdf_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    nbdf_core #(
        .BUFFER_CAPACITY (BUFFER_CAPACITY)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .command_flag (serial.command_flag),
        .word_byte    (serial.word_byte),
        .cfg          (cfg),
        .has_result   (has_result),
        .result       (result)
    );

    nbdf_out_buf u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (has_result),
        .push_word (result),
        .can_take  (can_take),
        .out_valid (datagram.valid),
        .out_ready (datagram.ready),
        .out_word  (out_word)
    );

    assign datagram.byte_value = out_word.byte_value;
    assign datagram.byte_index = out_word.byte_index;
    assign datagram.last       = out_word.last;
    assign datagram.status     = out_word.status;

endmodule

### rtl/nbdf_checker.sv
// ----------------------------------------------------------------------------
// nbdf_checker
// Port-level checks on the result channel of the datagram filter.
// ----------------------------------------------------------------------------
module nbdf_checker #(
    parameter int BUFFER_CAPACITY = 16
) (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] byte_value,
    input logic [4:0] byte_index,
    input logic       last,
    input logic [1:0] status
);
    import nbdf_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(byte_value) &&
        $stable(byte_index) && $stable(last) && $stable(status))
        else $error("result word changed while stalled");

    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last == (status != ST_STORED)))
        else $error("last flag disagrees with status");

    a_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_OVERFLOW |-> byte_value == 8'd0 && byte_index == 5'd0)
        else $error("overflow word carries data");

    a_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OVERFLOW |-> 32'(byte_index) < 32'(BUFFER_CAPACITY))
        else $error("byte index beyond buffer");

endmodule

bind nine_bit_datagram_filter nbdf_checker #(
    .BUFFER_CAPACITY (BUFFER_CAPACITY)
) u_nbdf_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (datagram.valid),
    .out_ready  (datagram.ready),
    .byte_value (datagram.byte_value),
    .byte_index (datagram.byte_index),
    .last       (datagram.last),
    .status     (datagram.status)
);

### sim/tb_nine_bit_datagram_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nine_bit_datagram_filter
// Feeds nine-bit words into the datagram filter, frames the same stream in a
// local predictor and checks every result word against it. It runs a short
// directed sequence, then random datagrams mixed with noise under several
// register settings, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_nine_bit_datagram_filter;
    import nbdf_pkg::*;

    localparam int BUF_CAP    = 16;
    localparam int QUIET_MAX  = 5000;
    localparam int LONG_HOLD  = 300;
    localparam int PHASES     = 7;
    localparam int PHASE_WORDS = 250;

    // indexes outside the register map, writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_NONE_LO = REG_MIN_LEN + 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NONE_HI = '1;

    typedef struct packed {
        logic       cmd;
        logic [7:0] b;
    } word_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    nbdf_serial_if serial_ch ();
    nbdf_result_if result_ch ();

    nine_bit_datagram_filter #(.BUFFER_CAPACITY(BUF_CAP)) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .serial    (serial_ch),
        .datagram  (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // register copy and framing state of the predictor
    logic [7:0] id_regs [4];
    logic [3:0] min_len;
    phase_t     fr_phase;
    logic [5:0] fr_pos;
    logic [4:0] fr_total;

    word_t   pending_words [$];
    result_t expected_bytes [$];

    int errors;
    bit src_gaps;
    bit snk_gaps;
    int long_hold_req;
    int long_hold_seen;
    int gap_left;
    int hold_left;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int draw_gap(input bit on);
        return on ? int'($urandom_range(0, 10)) : 0;
    endfunction

    function automatic bit frame_word(input logic cmd, input logic [7:0] b,
                                      output result_t r);
        r = '0;
        case (fr_phase)
            PH_ATTR:
            begin
                fr_total = {1'b0, b[3:0]} + {1'b0, min_len};
                r.byte_value = {4'h0, b[3:0]};
                r.byte_index = fr_pos[4:0];
                r.status = ST_STORED;
                fr_pos = fr_pos + 6'd1;
                fr_phase = PH_DATA;
                return 1'b1;
            end
            PH_DATA:
            begin
                if (fr_pos < BUF_CAP)
                begin
                    r.byte_value = b;
                    r.byte_index = fr_pos[4:0];
                    fr_pos = fr_pos + 6'd1;
                    if (fr_pos >= {1'b0, fr_total})
                    begin
                        fr_phase = PH_HUNT;
                        r.last = 1'b1;
                        r.status = ST_DONE;
                    end
                    else
                        r.status = ST_STORED;
                end
                else
                begin
                    fr_phase = PH_HUNT;
                    r.last = 1'b1;
                    r.status = ST_OVERFLOW;
                end
                return 1'b1;
            end
            default:
            begin
                fr_phase = PH_HUNT;
                if (cmd && (b == id_regs[0] || b == id_regs[1] ||
                            b == id_regs[2] || b == id_regs[3]))
                begin
                    fr_pos = 6'd1;
                    fr_phase = PH_ATTR;
                    r.byte_value = b;
                    r.status = ST_STORED;
                    return 1'b1;
                end
                return 1'b0;
            end
        endcase
    endfunction

    function automatic void push_word(input logic cmd, input logic [7:0] b);
        word_t w;
        w.cmd = cmd;
        w.b = b;
        pending_words.push_back(w);
    endfunction

    // start word, attribute word and enough data words to finish the datagram
    // (or to run into overflow); a cut datagram stops short
    function automatic int push_datagram(input logic [7:0] id, input logic [7:0] attr,
                                         input bit cut);
        int t;
        int n;
        t = int'(attr[3:0]) + int'(min_len);
        n = (t <= 3) ? 1 : ((t > BUF_CAP) ? BUF_CAP - 1 : t - 2);
        if (cut)
            n = $urandom_range(0, n - 1);
        push_word(1'b1, id);
        push_word(1'($urandom), attr);
        for (int i = 0; i < n; i++)
            push_word(1'($urandom), 8'($urandom));
        return n + 2;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_ID_A: id_regs[0] = val;
            REG_ID_B: id_regs[1] = val;
            REG_ID_C: id_regs[2] = val;
            REG_ID_D: id_regs[3] = val;
            REG_MIN_LEN: min_len = val[3:0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending_words.size() != 0 || serial_ch.valid ||
               expected_bytes.size() != 0 || result_ch.valid);
        repeat (3) @(posedge clk);
    endtask

    // word sender
    always @(posedge clk or negedge rst_n)
    begin : word_feed
        result_t r;
        word_t   w;
        if (!rst_n)
        begin
            serial_ch.valid <= 1'b0;
            serial_ch.command_flag <= 1'b0;
            serial_ch.word_byte <= 8'h00;
            gap_left <= 0;
        end
        else
        begin
            if (serial_ch.valid && serial_ch.ready)
            begin
                if (frame_word(serial_ch.command_flag, serial_ch.word_byte, r))
                    expected_bytes.push_back(r);
            end
            if (!serial_ch.valid || serial_ch.ready)
            begin
                if (gap_left != 0)
                begin
                    gap_left <= gap_left - 1;
                    serial_ch.valid <= 1'b0;
                end
                else if (pending_words.size() != 0)
                begin
                    w = pending_words.pop_front();
                    serial_ch.valid <= 1'b1;
                    serial_ch.command_flag <= w.cmd;
                    serial_ch.word_byte <= w.b;
                    gap_left <= draw_gap(src_gaps);
                end
                else
                    serial_ch.valid <= 1'b0;
            end
        end
    end

    // result receiver and checker
    always @(posedge clk or negedge rst_n)
    begin : result_mon
        result_t got;
        result_t want;
        int      n;
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            hold_left <= 0;
            long_hold_seen <= 0;
        end
        else
        begin
            n = 0;
            if (result_ch.valid && result_ch.ready)
            begin
                got.byte_value = result_ch.byte_value;
                got.byte_index = result_ch.byte_index;
                got.last = result_ch.last;
                got.status = result_ch.status;
                if (expected_bytes.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: unexpected word: value %h index %0d last %b status %0d",
                                 $time, got.byte_value, got.byte_index, got.last, got.status);
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (got !== want)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display({"%0t: mismatch: exp value %h index %0d last %b status %0d",
                                      ", got value %h index %0d last %b status %0d"},
                                     $time, want.byte_value, want.byte_index, want.last,
                                     want.status, got.byte_value, got.byte_index, got.last,
                                     got.status);
                    end
                end
                n = draw_gap(snk_gaps);
            end
            if (long_hold_req != long_hold_seen)
            begin
                long_hold_seen <= long_hold_req;
                hold_left <= LONG_HOLD;
                result_ch.ready <= 1'b0;
            end
            else if (n > 0)
            begin
                hold_left <= n - 1;
                result_ch.ready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_MAX)
        begin
            @(posedge clk);
            if ((serial_ch.valid && serial_ch.ready) ||
                (result_ch.valid && result_ch.ready) || cfg_we)
                quiet = 0;
            else
                quiet++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin : stimulus
        int  useful;
        int  k;
        logic [7:0] v;
        serial_ch.valid = 1'b0;
        serial_ch.command_flag = 1'b0;
        serial_ch.word_byte = 8'h00;
        result_ch.ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        errors = 0;
        src_gaps = 1'b0;
        snk_gaps = 1'b0;
        long_hold_req = 0;
        id_regs[0] = RST_ID_A;
        id_regs[1] = RST_ID_B;
        id_regs[2] = RST_ID_C;
        id_regs[3] = RST_ID_D;
        min_len = RST_MIN_LEN;
        fr_phase = PH_HUNT;
        fr_pos = '0;
        fr_total = '0;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed, reset register values
        push_word(1'b0, RST_ID_B);
        push_word(1'b1, 8'h55);
        void'(push_datagram(RST_ID_A, 8'hF0, 1'b0));
        void'(push_datagram(RST_ID_D, 8'h0F, 1'b0));
        void'(push_datagram(RST_ID_C, 8'h01, 1'b0));
        wait_drained();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    for (int i = 0; i < 4; i++)
                        write_reg(REG_ID_A + CFG_IDX_W'(i), 8'($urandom));
                    write_reg(REG_MIN_LEN, 8'd2);
                end
                1:
                begin
                    write_reg(REG_ID_A, 8'hFF);
                    write_reg(REG_ID_B, 8'hFE);
                    write_reg(REG_ID_C, 8'h01);
                    write_reg(REG_ID_D, 8'h80);
                    write_reg(REG_MIN_LEN, 8'd15);
                end
                2:
                begin
                    for (int i = 0; i < 4; i++)
                        write_reg(REG_ID_A + CFG_IDX_W'(i), 8'($urandom));
                    write_reg(REG_MIN_LEN, 8'd0);
                    write_reg(REG_NONE_LO, 8'($urandom));
                end
                3:
                begin
                    v = 8'($urandom);
                    for (int i = 0; i < 4; i++)
                        write_reg(REG_ID_A + CFG_IDX_W'(i), v);
                    write_reg(REG_MIN_LEN, 8'd1);
                end
                4:
                begin
                    for (int i = 0; i < 4; i++)
                        write_reg(REG_ID_A + CFG_IDX_W'(i), 8'($urandom));
                    // upper nibble must be dropped
                    write_reg(REG_MIN_LEN, 8'hF7);
                    write_reg(REG_NONE_LO + 3'd1, 8'($urandom));
                    write_reg(REG_NONE_HI, 8'($urandom));
                end
                5:
                begin
                    write_reg(REG_ID_A, 8'h00);
                    write_reg(REG_ID_B, 8'h00);
                    write_reg(REG_ID_C, 8'hFF);
                    write_reg(REG_ID_D, 8'hFF);
                    write_reg(REG_MIN_LEN, 8'($urandom_range(2, 15)));
                end
                default:
                begin
                    for (int i = 0; i < 4; i++)
                        write_reg(REG_ID_A + CFG_IDX_W'(i), 8'($urandom));
                    write_reg(REG_MIN_LEN, 8'($urandom_range(0, 15)));
                end
            endcase

            src_gaps = (ph % 3) != 0;
            snk_gaps = (ph % 2) != 0;
            if (ph == 2)
                long_hold_req++;

            useful = 0;
            while (useful < PHASE_WORDS)
            begin
                k = $urandom_range(0, 99);
                if (k < 80)
                    useful += push_datagram(id_regs[$urandom_range(0, 3)], 8'($urandom),
                                            k < 5);
                else if (k < 90)
                    push_word(1'b0, 8'($urandom));
                else
                    push_word(1'b1, 8'($urandom));
            end
            wait_drained();
        end

        repeat (10) @(posedge clk);
        errors += expected_bytes.size();
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
